[hw/rtl/mdc_pkg.sv]
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared types, codes and the compass letter lookup for the move deque.
// ----------------------------------------------------------------------------
package mdc_pkg;

	localparam int unsigned ACTION_W = 3;
	localparam int unsigned MOVE_W   = 3;
	localparam int unsigned LETTER_W = 7;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 9;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_BACK  = 3'd0,
		ACT_PUSH_FRONT = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_NEXT       = 3'd4,
		ACT_REWIND     = 3'd5
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic [MOVE_W-1:0] MV_NONE  = 3'd0;
	localparam logic [MOVE_W-1:0] MV_UP    = 3'd1;
	localparam logic [MOVE_W-1:0] MV_DOWN  = 3'd2;
	localparam logic [MOVE_W-1:0] MV_LEFT  = 3'd3;
	localparam logic [MOVE_W-1:0] MV_RIGHT = 3'd4;

	localparam logic [LETTER_W-1:0] LTR_N     = 7'h4e;
	localparam logic [LETTER_W-1:0] LTR_S     = 7'h53;
	localparam logic [LETTER_W-1:0] LTR_W     = 7'h57;
	localparam logic [LETTER_W-1:0] LTR_E     = 7'h45;
	localparam logic [LETTER_W-1:0] LTR_SPACE = 7'h20;

	typedef struct packed {
		logic                 give;
		status_t              status;
		logic [COUNT_W-1:0]   count;
	} ctrl_result_t;

	function automatic logic [LETTER_W-1:0] letter_of(input logic [MOVE_W-1:0] mv);
		logic [LETTER_W-1:0] l;
		case (mv)
			MV_UP:    l = LTR_N;
			MV_DOWN:  l = LTR_S;
			MV_LEFT:  l = LTR_W;
			MV_RIGHT: l = LTR_E;
			default:  l = LTR_SPACE;
		endcase
		return l;
	endfunction

endpackage

[hw/rtl/mdc_if.sv]
// ----------------------------------------------------------------------------
// mdc channel interfaces
// Valid/ready channels carrying operation words in and result words out.
// ----------------------------------------------------------------------------
interface mdc_in_if import mdc_pkg::*;;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [MOVE_W-1:0]   move_code;

	modport source (output valid, output action, output move_code, input ready);
	modport sink   (input valid, input action, input move_code, output ready);
endinterface

interface mdc_out_if import mdc_pkg::*;;
	logic                valid;
	logic                ready;
	logic [MOVE_W-1:0]   move_out;
	logic [LETTER_W-1:0] move_letter;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, output move_out, output move_letter, output status,
		output entry_count, input ready);
	modport sink   (input valid, input move_out, input move_letter, input status,
		input entry_count, output ready);
endinterface

[hw/rtl/mdc_store.sv]
// ----------------------------------------------------------------------------
// mdc_store
// Move code ring memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module mdc_store import mdc_pkg::*; #(
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [MOVE_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [MOVE_W-1:0] rdata
);

	logic [MOVE_W-1:0] mem [DEPTH];
	logic [MOVE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/mdc_ctrl.sv]
// ----------------------------------------------------------------------------
// mdc_ctrl
// Head, count and cursor registers; decodes each word into memory access.
// ----------------------------------------------------------------------------
module mdc_ctrl import mdc_pkg::*; #(
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = $clog2(DEPTH),
	localparam int unsigned CW = AW + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  action_t           action,
	input  logic [MOVE_W-1:0] move_code,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [MOVE_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	output ctrl_result_t      res
);

	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

	logic [AW-1:0] head_q, head_n, head_inc, head_dec, slot;
	logic [CW-1:0] count_q, count_n, cursor_q, cursor_n, off, sum;
	logic          full, empty;

	assign full     = count_q == DEPTH_C;
	assign empty    = count_q == '0;
	assign head_inc = (head_q == LAST_C) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? LAST_C : head_q - AW'(1);
	assign sum      = CW'(head_q) + off;
	assign slot     = (sum >= DEPTH_C) ? AW'(sum - DEPTH_C) : sum[AW-1:0];

	// offset from head of the entry touched
	always_comb begin
		case (action)
			ACT_PUSH_BACK: off = count_q;
			ACT_POP_BACK:  off = count_q - CW'(1);
			ACT_NEXT:      off = cursor_q;
			default:       off = '0;
		endcase
	end

	always_comb begin
		head_n     = head_q;
		count_n    = count_q;
		cursor_n   = cursor_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_waddr  = slot;
		res.give   = 1'b0;
		res.status = ST_OK;
		case (action)
			ACT_PUSH_BACK: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					mem_we  = 1'b1;
					count_n = count_q + CW'(1);
				end
			end
			ACT_PUSH_FRONT: begin
				mem_waddr = head_dec;
				if (full) begin
					res.status = ST_FULL;
				end else begin
					mem_we   = 1'b1;
					head_n   = head_dec;
					count_n  = count_q + CW'(1);
					cursor_n = '0;
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					mem_re   = 1'b1;
					res.give = 1'b1;
					head_n   = head_inc;
					count_n  = count_q - CW'(1);
					cursor_n = (cursor_q != '0) ? cursor_q - CW'(1) : '0;
					if (count_q == CW'(1)) begin
						head_n   = '0;
						cursor_n = '0;
					end
				end
			end
			ACT_POP_BACK: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					mem_re   = 1'b1;
					res.give = 1'b1;
					count_n  = count_q - CW'(1);
					if (cursor_q > count_q - CW'(1)) begin
						cursor_n = count_q - CW'(1);
					end
					if (count_q == CW'(1)) begin
						head_n   = '0;
						cursor_n = '0;
					end
				end
			end
			ACT_NEXT: begin
				if (cursor_q >= count_q) begin
					res.status = ST_EMPTY;
				end else begin
					mem_re   = 1'b1;
					res.give = 1'b1;
					cursor_n = cursor_q + CW'(1);
				end
			end
			ACT_REWIND: begin
				cursor_n = '0;
			end
			default: begin
			end
		endcase
		mem_we    = mem_we & accept;
		mem_re    = mem_re & accept;
		res.count = COUNT_W'(count_n);
	end

	assign mem_raddr = slot;
	assign mem_wdata = move_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			cursor_q <= '0;
		end else if (accept) begin
			head_q   <= head_n;
			count_q  <= count_n;
			cursor_q <= cursor_n;
		end
	end

endmodule

[hw/rtl/move_deque_with_cursor.sv]
// ----------------------------------------------------------------------------
// move_deque_with_cursor
// Bounded double-ended queue of move codes with a read cursor, ring memory.
// ----------------------------------------------------------------------------
// a result word appears in the cycle after its operation word is taken
// throughput: one word per cycle unless stalled, set by one mem r/w port pair
// reset clears head, count and cursor at once; memory contents stay undefined
// no clearing pass, the deque is usable as soon as reset is released
module move_deque_with_cursor import mdc_pkg::*; #(
	parameter int unsigned DEPTH = 256
) (
	input logic        clk,
	input logic        arst_n,
	mdc_in_if.sink     in_ch,
	mdc_out_if.source  out_ch
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic              accept;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [MOVE_W-1:0] mem_wdata, mem_rdata, move_out;
	ctrl_result_t      res, res_s1;
	logic              valid_s1;

	assign in_ch.ready = !valid_s1 || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	mdc_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action_t'(in_ch.action)),
		.move_code (in_ch.move_code),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res       (res)
	);

	mdc_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign move_out           = res_s1.give ? mem_rdata : MV_NONE;
	assign out_ch.valid       = valid_s1;
	assign out_ch.move_out    = move_out;
	assign out_ch.move_letter = letter_of(move_out);
	assign out_ch.status      = res_s1.status;
	assign out_ch.entry_count = res_s1.count;

	a_give_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_s1.give |-> res_s1.status == ST_OK)
		else $error("move given with non-ok status");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_s1.status == ST_FULL |-> res_s1.count == COUNT_W'(DEPTH))
		else $error("full status with count below depth");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted word produced no result");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_ch.ready |-> !accept)
		else $error("word taken while result stalled");

endmodule
